[hdl/pdu_pkg.sv]
// ----------------------------------------------------------------------------
// pdu_pkg: shared types and constants of the planar distance unit
// Widths, mode codes, reciprocal constant and the square-root cell bus.
// ----------------------------------------------------------------------------
`default_nettype none

package pdu_pkg;

  // field widths
  localparam int CoordW = 15;
  localparam int DistW  = 16;
  localparam int ModeW  = 2;

  // square-root datapath
  localparam int SumW     = 32;
  localparam int RemW     = 20;
  localparam int RootW    = 16;
  localparam int NumCells = SumW / 2;

  // approximation widths and constants
  localparam int ScaledW    = 21;
  localparam int RecipW     = 22;
  localparam int ProdW      = ScaledW + RecipW;
  localparam int RecipShift = 28;
  // ceil(2^28 / 102): exact floor division for every 21-bit dividend
  localparam logic [RecipW-1:0] RecipMul = 22'd2631721;
  localparam int CorrShift  = 7;

  // approximation mode codes
  localparam logic [ModeW-1:0] ModeExact  = 2'd0;
  localparam logic [ModeW-1:0] ModeRefine = 2'd1;
  localparam logic [ModeW-1:0] ModeOctal  = 2'd2;

  // register map
  localparam int PaddrW = 3;
  localparam logic RegApproxMode = 1'b0;

  // beat travelling down the row of square-root cells
  typedef struct packed {
    logic             valid;
    logic [SumW-1:0]  radicand;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic             use_approx;
    logic [DistW-1:0] approx;
  } pdu_cell_t;

endpackage

`default_nettype wire

[hdl/pdu_prep.sv]
// ----------------------------------------------------------------------------
// pdu_prep: front stages of the planar distance unit
// Forms the differences, the sum of squares and the max/min approximations,
// and loads the first square-root cell.
// ----------------------------------------------------------------------------
`default_nettype none

module pdu_prep (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  en_i,
  input  wire                                  valid_i,
  input  wire  [pdu_pkg::CoordW-1:0]           first_x_i,
  input  wire  [pdu_pkg::CoordW-1:0]           first_y_i,
  input  wire  [pdu_pkg::CoordW-1:0]           second_x_i,
  input  wire  [pdu_pkg::CoordW-1:0]           second_y_i,
  input  wire  [pdu_pkg::ModeW-1:0]            mode_i,
  output pdu_pkg::pdu_cell_t                   cell_o
);
  import pdu_pkg::*;

  // stage one registers
  logic              s1_valid_q;
  logic [CoordW-1:0] s1_dx_q, s1_dy_q, s1_big_q, s1_small_q;
  logic [ModeW-1:0]  s1_mode_q;

  // stage two registers
  logic              s2_valid_q;
  logic [SumW-1:0]   s2_sum_q;
  logic [CoordW-1:0] s2_big_q, s2_small_q, s2_quot_q;
  logic              s2_corr_q;
  logic [ModeW-1:0]  s2_mode_q;

  // stage three (cell load) register
  pdu_cell_t s3_q, s3_d;

  // stage one: absolute differences and ordering
  logic [CoordW-1:0] dx_d, dy_d;
  always_comb begin
    dx_d = (first_x_i > second_x_i) ? first_x_i - second_x_i : second_x_i - first_x_i;
    dy_d = (first_y_i > second_y_i) ? first_y_i - second_y_i : second_y_i - first_y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_dx_q    <= dx_d;
      s1_dy_q    <= dy_d;
      s1_big_q   <= (dx_d < dy_d) ? dy_d : dx_d;
      s1_small_q <= (dx_d < dy_d) ? dx_d : dy_d;
      s1_mode_q  <= mode_i;
    end
  end

  // stage two: squares, and 44*min/102 by reciprocal multiplication
  logic [SumW-1:0]    sq_x, sq_y, sum_d;
  logic [ScaledW-1:0] scaled;
  logic [ProdW-1:0]   prod;
  logic [CoordW+4:0]  small_x16;
  always_comb begin
    sq_x      = SumW'(s1_dx_q) * SumW'(s1_dx_q);
    sq_y      = SumW'(s1_dy_q) * SumW'(s1_dy_q);
    sum_d     = sq_x + sq_y;
    scaled    = (ScaledW'(s1_small_q) << 5) + (ScaledW'(s1_small_q) << 3)
              + (ScaledW'(s1_small_q) << 2);
    prod      = ProdW'(scaled) * ProdW'(RecipMul);
    small_x16 = {1'b0, s1_small_q, 4'b0000};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sum_q   <= sum_d;
      s2_big_q   <= s1_big_q;
      s2_small_q <= s1_small_q;
      s2_quot_q  <= prod[RecipShift +: CoordW];
      s2_corr_q  <= {5'b00000, s1_big_q} < small_x16;
      s2_mode_q  <= s1_mode_q;
    end
  end

  // stage three: approximations and loading of the first cell
  logic [CoordW+2:0] big_x5;
  logic [DistW-1:0]  refine, octal;
  always_comb begin
    big_x5 = (CoordW+3)'(s2_big_q) + ((CoordW+3)'(s2_big_q) << 2);
    refine = DistW'(s2_big_q) + DistW'(s2_quot_q)
           - (s2_corr_q ? DistW'(big_x5 >> CorrShift) : '0);
    octal  = DistW'(s2_big_q) + DistW'(s2_small_q >> 1);

    s3_d            = '0;
    s3_d.valid      = s2_valid_q;
    s3_d.radicand   = s2_sum_q;
    s3_d.use_approx = (s2_mode_q == ModeRefine) || (s2_mode_q == ModeOctal);
    case (s2_mode_q)
      ModeRefine: s3_d.approx = refine;
      ModeOctal:  s3_d.approx = octal;
      default:    s3_d.approx = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (en_i) begin
      s3_q <= s3_d;
    end
  end

  assign cell_o = s3_q;

endmodule

`default_nettype wire

[hdl/pdu_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// pdu_sqrt_cell: one step of the digit-by-digit square root
// Brings down two radicand bits, tries the next root bit and passes the beat on.
// ----------------------------------------------------------------------------
`default_nettype none

module pdu_sqrt_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 en_i,
  input  pdu_pkg::pdu_cell_t  cell_i,
  output pdu_pkg::pdu_cell_t  cell_o
);
  import pdu_pkg::*;

  pdu_cell_t       cell_q, cell_d;
  logic [RemW-1:0] rem_sh, trial;
  logic            fits;

  // one restoring step: remainder gains two bits, root gains one
  always_comb begin
    rem_sh = {cell_i.rem[RemW-3:0], cell_i.radicand[SumW-1 -: 2]};
    trial  = {{(RemW-RootW-2){1'b0}}, cell_i.root, 2'b01};
    fits   = rem_sh >= trial;

    cell_d          = cell_i;
    cell_d.radicand = {cell_i.radicand[SumW-3:0], 2'b00};
    cell_d.rem      = fits ? rem_sh - trial : rem_sh;
    cell_d.root     = {cell_i.root[RootW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

[hdl/planar_distance_unit.sv]
// ----------------------------------------------------------------------------
// planar_distance_unit: distance between two points
// Exact truncated root or max/min approximations, chosen by approx_mode.
// ----------------------------------------------------------------------------
// stages from input beat to valid_o: 3 front stages, 16 root cells,
//   output register
// one beat per cycle while stall_o is low; each root cell settles one result bit
// a one-beat skid register behind the output holds a result when stall_i is high
// reset clears all valid bits and sets approx_mode to 0 (exact)
`default_nettype none

module planar_distance_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // input channel
  input  wire                          valid_i,
  output logic                         stall_o,
  input  wire  [pdu_pkg::CoordW-1:0]   first_x_i,
  input  wire  [pdu_pkg::CoordW-1:0]   first_y_i,
  input  wire  [pdu_pkg::CoordW-1:0]   second_x_i,
  input  wire  [pdu_pkg::CoordW-1:0]   second_y_i,
  // output channel
  output logic                         valid_o,
  input  wire                          stall_i,
  output logic [pdu_pkg::DistW-1:0]    distance_o,
  // configuration port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [pdu_pkg::PaddrW-1:0]   paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import pdu_pkg::*;

  logic [ModeW-1:0] mode_q;
  logic             adv;
  pdu_cell_t        chain [NumCells+1];

  logic             out_valid_q, skid_valid_q;
  logic [DistW-1:0] out_data_q, skid_data_q;
  logic [DistW-1:0] pipe_data;
  logic             out_take;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeExact;
    end else if (psel && penable && pwrite && (paddr[PaddrW-1] == RegApproxMode)) begin
      mode_q <= pwdata[ModeW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PaddrW-1] == RegApproxMode) begin
      prdata = {{(32-ModeW){1'b0}}, mode_q};
    end
  end

  // whole pipeline moves unless the skid register is occupied
  assign adv     = !skid_valid_q;
  assign stall_o = skid_valid_q;

  // front stages
  pdu_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (valid_i),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .mode_i     (mode_q),
    .cell_o     (chain[0])
  );

  // row of square-root cells
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    pdu_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  assign pipe_data = chain[NumCells].use_approx ? chain[NumCells].approx
                                                : chain[NumCells].root;
  assign out_take  = out_valid_q && !stall_i;

  // output register and skid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (chain[NumCells].valid) begin
      if (out_valid_q && stall_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_data_q <= skid_data_q;
      end
    end else if (chain[NumCells].valid) begin
      if (out_valid_q && stall_i) begin
        skid_data_q <= pipe_data;
      end else begin
        out_data_q <= pipe_data;
      end
    end
  end

  assign valid_o    = out_valid_q;
  assign distance_o = out_data_q;

  // skid only ever holds a beat behind a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  // skid fills only when the output was stalled and a result arrived
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && stall_i && chain[NumCells].valid))
    else $error("skid register filled without a stalled output");

  // a new result appears only from the last cell or from the skid register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(chain[NumCells].valid || skid_valid_q))
    else $error("output valid without a source beat");

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the planar distance unit
// Drives point pairs through the valid/stall input channel, predicts each
// distance for the programmed approx_mode and compares it with the output
// beat. A short table of directed pairs comes first, then random pairs
// under several modes and idling profiles, including a long output hold-off.
// ----------------------------------------------------------------------------

module tb_top;
  import pdu_pkg::*;

  // unused mode code, must behave like the exact root
  localparam logic [ModeW-1:0] ModeSpare = 2'd3;

  localparam int NumRows     = 22;
  localparam int NumSegments = 8;
  localparam int SegItems    = 178;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 40;
  localparam int ReportLimit = 10;

  // one directed pair, with the distance typed in where it is obvious
  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [CoordW-1:0] ax;
    logic [CoordW-1:0] ay;
    logic [CoordW-1:0] bx;
    logic [CoordW-1:0] by;
    logic              typed;
    logic [DistW-1:0]  exp_dist;
  } pair_row_t;

  localparam pair_row_t DirRows [NumRows] = '{
    // exact root: zero, axis extremes, diagonal extreme, 3-4-5, coincident, alternating bits
    '{ModeExact,  15'd0,      15'd0,      15'd0,      15'd0,      1'b1, 16'd0},
    '{ModeExact,  15'd32767,  15'd0,      15'd0,      15'd0,      1'b1, 16'd32767},
    '{ModeExact,  15'd0,      15'd0,      15'd0,      15'd32767,  1'b1, 16'd32767},
    '{ModeExact,  15'd0,      15'd0,      15'd32767,  15'd32767,  1'b1, 16'd46339},
    '{ModeExact,  15'd32767,  15'd32767,  15'd0,      15'd0,      1'b1, 16'd46339},
    '{ModeExact,  15'd3,      15'd4,      15'd0,      15'd0,      1'b1, 16'd5},
    '{ModeExact,  15'd100,    15'd200,    15'd100,    15'd200,    1'b1, 16'd0},
    '{ModeExact,  15'h5555,   15'h2aaa,   15'h2aaa,   15'h5555,   1'b0, 16'd0},
    // refined approximation: extremes, equal magnitudes, 16x ratio edge,
    // both orders of the points
    '{ModeRefine, 15'd0,      15'd0,      15'd0,      15'd0,      1'b1, 16'd0},
    '{ModeRefine, 15'd0,      15'd0,      15'd32767,  15'd0,      1'b1, 16'd32767},
    '{ModeRefine, 15'd32767,  15'd32767,  15'd0,      15'd0,      1'b0, 16'd0},
    '{ModeRefine, 15'd1000,   15'd1000,   15'd0,      15'd0,      1'b0, 16'd0},
    '{ModeRefine, 15'd0,      15'd0,      15'd160,    15'd10,     1'b0, 16'd0},
    '{ModeRefine, 15'd0,      15'd0,      15'd159,    15'd10,     1'b0, 16'd0},
    '{ModeRefine, 15'd500,    15'd300,    15'd0,      15'd0,      1'b0, 16'd0},
    '{ModeRefine, 15'd0,      15'd0,      15'd500,    15'd300,    1'b0, 16'd0},
    // octagonal: largest result both ways round, a small pair, zero
    '{ModeOctal,  15'd0,      15'd0,      15'd32767,  15'd32767,  1'b1, 16'd49150},
    '{ModeOctal,  15'd32767,  15'd0,      15'd0,      15'd32767,  1'b1, 16'd49150},
    '{ModeOctal,  15'd10,     15'd0,      15'd0,      15'd7,      1'b0, 16'd0},
    '{ModeOctal,  15'd0,      15'd0,      15'd0,      15'd0,      1'b1, 16'd0},
    // unused mode falls back to the exact root
    '{ModeSpare,  15'd0,      15'd0,      15'd3,      15'd4,      1'b1, 16'd5},
    '{ModeSpare,  15'd32767,  15'd32767,  15'd0,      15'd0,      1'b1, 16'd46339}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              valid_i;
  logic              stall_o;
  logic [CoordW-1:0] first_x_i;
  logic [CoordW-1:0] first_y_i;
  logic [CoordW-1:0] second_x_i;
  logic [CoordW-1:0] second_y_i;
  logic              valid_o;
  logic              stall_i;
  logic [DistW-1:0]  distance_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // distances still owed by the block, oldest first
  logic [DistW-1:0]  owed_dist_q [$];
  logic [ModeW-1:0]  cur_mode;
  int unsigned       error_count = 0;
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_idle_pct = 0;
  int unsigned       hold_asked  = 0;
  int unsigned       hold_given  = 0;
  int unsigned       hold_left   = 0;

  planar_distance_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .stall_o    (stall_o),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .distance_o (distance_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // distance for one point pair under the given mode
  function automatic logic [DistW-1:0] predict_distance(
    input logic [ModeW-1:0] mode, input logic [CoordW-1:0] ax, input logic [CoordW-1:0] ay,
    input logic [CoordW-1:0] bx, input logic [CoordW-1:0] by);
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] major;
    logic [31:0] minor;
    logic [31:0] acc;
    logic [31:0] rem;
    logic [31:0] probe;
    dx = (ax > bx) ? 32'(ax - bx) : 32'(bx - ax);
    dy = (ay > by) ? 32'(ay - by) : 32'(by - ay);
    major = (dx < dy) ? dy : dx;
    minor = (dx < dy) ? dx : dy;
    case (mode)
      ModeRefine: begin
        acc = major + (32'd44 * minor) / 32'd102;
        if (major < (minor << 4)) begin
          acc = acc - ((32'd5 * major) >> CorrShift);
        end
      end
      ModeOctal: begin
        acc = major + (minor >> 1);
      end
      default: begin
        // bit-by-bit truncating square root
        rem   = dx * dx + dy * dy;
        acc   = 32'd0;
        probe = 32'd1 << 30;
        while (probe > rem) probe = probe >> 2;
        while (probe != 32'd0) begin
          if (rem >= acc + probe) begin
            rem = rem - (acc + probe);
            acc = acc + 2 * probe;
          end
          probe = probe >> 2;
          acc   = acc >> 1;
        end
      end
    endcase
    return acc[DistW-1:0];
  endfunction

  task automatic note_failure(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    error_count++;
    if (error_count <= ReportLimit) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // output side: stall pattern and the long hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      stall_i   <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      stall_i    <= 1'b1;
      hold_left  <= HoldCycles;
      hold_given <= hold_given + 1;
    end else begin
      stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // output beat check against the oldest owed distance
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (owed_dist_q.size() == 0) begin
        note_failure("unexpected beat", 32'd0, 32'(distance_o));
      end else if (distance_o !== owed_dist_q[0]) begin
        note_failure("distance", 32'(owed_dist_q[0]), 32'(distance_o));
        void'(owed_dist_q.pop_front());
      end else begin
        void'(owed_dist_q.pop_front());
      end
    end
  end

  // offer one pair until accepted, with optional idle cycles before it
  task automatic send_pair(input logic [CoordW-1:0] ax, input logic [CoordW-1:0] ay,
                           input logic [CoordW-1:0] bx, input logic [CoordW-1:0] by,
                           input logic typed, input logic [DistW-1:0] exp_dist);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i    <= 1'b1;
    first_x_i  <= ax;
    first_y_i  <= ay;
    second_x_i <= bx;
    second_y_i <= by;
    do @(posedge clk_i); while (stall_o);
    owed_dist_q.push_back(typed ? exp_dist : predict_distance(cur_mode, ax, ay, bx, by));
  endtask

  // wait for the block to drain, then write approx_mode and read it back
  task automatic program_mode(input logic [ModeW-1:0] mode);
    valid_i <= 1'b0;
    while (owed_dist_q.size() != 0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'(4 * int'(RegApproxMode));
    pwdata  <= 32'(mode);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cur_mode = mode;
    // read back, straight into the next setup phase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(mode)) begin
      note_failure("approx_mode read", 32'(mode), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random pair, biased towards the interesting geometries
  task automatic make_pair(output logic [CoordW-1:0] ax, output logic [CoordW-1:0] ay,
                           output logic [CoordW-1:0] bx, output logic [CoordW-1:0] by);
    int unsigned kind;
    int          major;
    int          minor;
    logic [CoordW-1:0] t;
    kind = $urandom_range(0, 9);
    ax = CoordW'($urandom_range(0, 32767));
    ay = CoordW'($urandom_range(0, 32767));
    bx = CoordW'($urandom_range(0, 32767));
    by = CoordW'($urandom_range(0, 32767));
    case (kind)
      5: begin
        // close together
        bx = ax ^ CoordW'($urandom_range(0, 63));
        by = ay ^ CoordW'($urandom_range(0, 63));
      end
      6: by = ay;
      7, 8: begin
        // equal magnitudes, or a ratio right at the 16x edge
        minor = $urandom_range(0, (kind == 7) ? 16383 : 2047);
        major = (kind == 7) ? minor : 16 * minor - 1 + int'($urandom_range(0, 2));
        if (major < 0) major = 0;
        ax = CoordW'($urandom_range(0, 32767 - major));
        bx = CoordW'(int'(ax) + major);
        ay = CoordW'($urandom_range(minor, 32767));
        by = CoordW'(int'(ay) - minor);
        if ($urandom_range(0, 1) != 0) begin
          t = ax; ax = ay; ay = t;
          t = bx; bx = by; by = t;
        end
        if ($urandom_range(0, 1) != 0) begin
          t = ax; ax = bx; bx = t;
          t = ay; ay = by; by = t;
        end
      end
      9: begin
        if ($urandom_range(0, 2) == 0) ax = {CoordW{$urandom_range(0, 1) != 0}};
        if ($urandom_range(0, 2) == 0) ay = {CoordW{$urandom_range(0, 1) != 0}};
        if ($urandom_range(0, 2) == 0) bx = {CoordW{$urandom_range(0, 1) != 0}};
        if ($urandom_range(0, 2) == 0) by = {CoordW{$urandom_range(0, 1) != 0}};
      end
      default: ;
    endcase
  endtask

  // main sequence
  initial begin
    logic [ModeW-1:0]  seg_mode [NumSegments];
    logic [CoordW-1:0] ax;
    logic [CoordW-1:0] ay;
    logic [CoordW-1:0] bx;
    logic [CoordW-1:0] by;
    seg_mode = '{ModeRefine, ModeOctal, ModeExact, ModeSpare,
                 ModeOctal, ModeRefine, ModeExact, ModeRefine};
    rst_ni     <= 1'b0;
    valid_i    <= 1'b0;
    stall_i    <= 1'b0;
    first_x_i  <= '0;
    first_y_i  <= '0;
    second_x_i <= '0;
    second_y_i <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    cur_mode = ModeExact;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // dense input, busy output to start with
    tx_idle_pct = 7;
    rx_idle_pct = 87;

    // directed table
    for (int r = 0; r < NumRows; r++) begin
      if (DirRows[r].mode != cur_mode) program_mode(DirRows[r].mode);
      send_pair(DirRows[r].ax, DirRows[r].ay, DirRows[r].bx, DirRows[r].by,
                DirRows[r].typed, DirRows[r].exp_dist);
    end

    // random segments, each under a programmed mode and one of three idling profiles
    for (int s = 0; s < NumSegments; s++) begin
      program_mode(seg_mode[s]);
      if (s >= 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (s >= 3) begin
        tx_idle_pct = 87;
        rx_idle_pct = 7;
      end
      // long output hold-off while pairs keep coming, so the pipe backs up
      if (s == 6) hold_asked = hold_asked + 1;
      for (int n = 0; n < SegItems; n++) begin
        make_pair(ax, ay, bx, by);
        send_pair(ax, ay, bx, by, 1'b0, '0);
      end
    end
    valid_i <= 1'b0;

    while (owed_dist_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (owed_dist_q.size() != 0) begin
      note_failure("missing beats", 32'd0, 32'(owed_dist_q.size()));
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
